@@ hdl/assert_macros.svh @@
// assertion macros for the rtl of the token finder
// needs a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define DTF_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define DTF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/dtf_pkg.sv @@
// constants, register indexes and the byte class function of the token finder
// no dependencies
`timescale 1ns / 1ps

package dtf_pkg;

  // field widths
  localparam int BYTE_W    = 8;
  localparam int POS_W     = 16;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_CHAR  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_CHAR = 1'd1;

  // register reset values
  localparam logic [BYTE_W-1:0] OPEN_CHAR_RST  = 8'd40;
  localparam logic [BYTE_W-1:0] CLOSE_CHAR_RST = 8'd41;

  // special characters
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_EQUALS = 8'h3D;
  localparam logic [BYTE_W-1:0] CH_UNDER  = 8'h5F;
  localparam logic [BYTE_W-1:0] CH_DASH   = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;

  // length limits
  localparam logic [POS_W-1:0] MAX_LEN       = 16'hFFFF;
  localparam logic [POS_W-1:0] MIN_MATCH_LEN = 16'd4;

  // bytes allowed in reference content before its first equals sign
  function automatic logic allowed_byte(input logic [BYTE_W-1:0] c);
    logic ok;
    ok = 1'b0;
    if (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]}) ok = 1'b1;
    if ((c inside {[8'hC0:8'hFF]}) && (c != 8'hD7) && (c != 8'hF7)) ok = 1'b1;
    if ((c == CH_UNDER) || (c == CH_DASH) || (c == CH_SLASH)) ok = 1'b1;
    return ok;
  endfunction

endpackage

@@ hdl/delimited_token_finder_unit.sv @@
// delimited token finder: scans a byte stream for $<open>content<close>
// depends on dtf_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// channel  | direction | ports
// input    | in        | in_valid, in_stall, in_text_byte, in_last_byte
// result   | out       | out_valid, out_stall, out_found, out_content_offset,
//          |           | out_content_length, out_too_long
// config   | in        | cfg_wr_en, cfg_index, cfg_wr_data
//
// one byte per cycle while in_stall is low: the scan flags and position counter
// update in the cycle a byte is taken, so back-to-back bytes never wait on each other
// the result of a string appears in the result register in the cycle after its last byte
// input stalls only while that result register is full and the result side stalls
// synchronous active-low reset restores open '(' / close ')' and clears the scan

module delimited_token_finder_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [dtf_pkg::BYTE_W-1:0]   in_text_byte,
  input  logic                         in_last_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_found,
  output logic [dtf_pkg::POS_W-1:0]    out_content_offset,
  output logic [dtf_pkg::POS_W-1:0]    out_content_length,
  output logic                         out_too_long,
  input  logic                         cfg_wr_en,
  input  logic [dtf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dtf_pkg::BYTE_W-1:0]   cfg_wr_data
);

  // configuration registers
  logic [dtf_pkg::BYTE_W-1:0] open_char_r, close_char_r;

  // scan state
  logic [dtf_pkg::POS_W-1:0] byte_position_r, byte_position_nxt;
  logic                      prev_was_dollar_r, prev_was_dollar_nxt;
  logic                      cand_open_r, cand_open_nxt;
  logic                      cand_good_r, cand_good_nxt;
  logic                      cand_past_eq_r, cand_past_eq_nxt;
  logic [dtf_pkg::POS_W-1:0] cand_start_r, cand_start_nxt;
  logic                      match_done_r, match_done_nxt;
  logic [dtf_pkg::POS_W-1:0] match_start_r, match_start_nxt;
  logic [dtf_pkg::POS_W-1:0] match_length_r, match_length_nxt;
  logic                      overflowed_r, overflowed_nxt;

  // result register
  logic                      out_valid_r, out_valid_nxt;
  logic                      found_r, found_nxt;
  logic [dtf_pkg::POS_W-1:0] offset_r, offset_nxt;
  logic [dtf_pkg::POS_W-1:0] length_r, length_nxt;
  logic                      too_long_r, too_long_nxt;

  logic in_accept;
  logic load_result;
  logic hit;

  // handshake
  assign in_stall    = out_valid_r && out_stall;
  assign in_accept   = in_valid && !in_stall;
  assign load_result = in_accept && in_last_byte;

  // per-byte scan step
  always_comb begin
    byte_position_nxt   = byte_position_r;
    prev_was_dollar_nxt = prev_was_dollar_r;
    cand_open_nxt       = cand_open_r;
    cand_good_nxt       = cand_good_r;
    cand_past_eq_nxt    = cand_past_eq_r;
    cand_start_nxt      = cand_start_r;
    match_done_nxt      = match_done_r;
    match_start_nxt     = match_start_r;
    match_length_nxt    = match_length_r;
    overflowed_nxt      = overflowed_r;
    if (in_accept) begin
      if (byte_position_r >= dtf_pkg::MAX_LEN) begin
        overflowed_nxt = 1'b1;
      end else begin
        // pending candidate: close or check content
        if (!match_done_r && cand_open_r) begin
          if (in_text_byte == close_char_r) begin
            if (cand_good_r) begin
              match_done_nxt   = 1'b1;
              match_start_nxt  = cand_start_r;
              match_length_nxt = byte_position_r - cand_start_r;
            end
            cand_open_nxt = 1'b0;
          end else if (!cand_past_eq_r) begin
            if (in_text_byte == dtf_pkg::CH_EQUALS) begin
              cand_past_eq_nxt = 1'b1;
            end else if (!dtf_pkg::allowed_byte(in_text_byte)) begin
              cand_good_nxt = 1'b0;
            end
          end
        end
        // dollar-open opens a new candidate unless matched or a good one is pending
        if (!match_done_nxt && prev_was_dollar_r && (in_text_byte == open_char_r) &&
            (!cand_open_nxt || !cand_good_nxt)) begin
          cand_open_nxt    = 1'b1;
          cand_good_nxt    = 1'b1;
          cand_past_eq_nxt = 1'b0;
          cand_start_nxt   = byte_position_r + 16'd1;
        end
        prev_was_dollar_nxt = (in_text_byte == dtf_pkg::CH_DOLLAR);
        byte_position_nxt   = byte_position_r + 16'd1;
      end
    end
  end

  // result of the string ending at this byte
  assign hit = match_done_nxt &&
               (overflowed_nxt || (byte_position_nxt >= dtf_pkg::MIN_MATCH_LEN));

  always_comb begin
    out_valid_nxt = out_valid_r;
    found_nxt     = found_r;
    offset_nxt    = offset_r;
    length_nxt    = length_r;
    too_long_nxt  = too_long_r;
    if (load_result) begin
      out_valid_nxt = 1'b1;
      found_nxt     = hit;
      offset_nxt    = hit ? match_start_nxt : '0;
      length_nxt    = hit ? match_length_nxt : '0;
      too_long_nxt  = overflowed_nxt;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_char_r  <= dtf_pkg::OPEN_CHAR_RST;
      close_char_r <= dtf_pkg::CLOSE_CHAR_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        dtf_pkg::REG_OPEN_CHAR:  open_char_r  <= cfg_wr_data;
        dtf_pkg::REG_CLOSE_CHAR: close_char_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // scan state, cleared on reset and after the last byte of a string
  always_ff @(posedge clk) begin
    if (!rst_n || load_result) begin
      byte_position_r   <= '0;
      prev_was_dollar_r <= 1'b0;
      cand_open_r       <= 1'b0;
      cand_good_r       <= 1'b1;
      cand_past_eq_r    <= 1'b0;
      cand_start_r      <= '0;
      match_done_r      <= 1'b0;
      match_start_r     <= '0;
      match_length_r    <= '0;
      overflowed_r      <= 1'b0;
    end else begin
      byte_position_r   <= byte_position_nxt;
      prev_was_dollar_r <= prev_was_dollar_nxt;
      cand_open_r       <= cand_open_nxt;
      cand_good_r       <= cand_good_nxt;
      cand_past_eq_r    <= cand_past_eq_nxt;
      cand_start_r      <= cand_start_nxt;
      match_done_r      <= match_done_nxt;
      match_start_r     <= match_start_nxt;
      match_length_r    <= match_length_nxt;
      overflowed_r      <= overflowed_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    found_r    <= found_nxt;
    offset_r   <= offset_nxt;
    length_r   <= length_nxt;
    too_long_r <= too_long_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_found          = found_r;
  assign out_content_offset = offset_r;
  assign out_content_length = length_r;
  assign out_too_long       = too_long_r;

  // checks
  `DTF_ASSERT_NXT(a_last_gives_result, load_result, out_valid_r, "last byte gave no result")
  `DTF_ASSERT_NXT(a_scan_cleared, load_result, !match_done_r && byte_position_r == '0, "scan held")
  `DTF_ASSERT(a_found_offset, out_valid_r && found_r, offset_r >= 16'd2, "match offset too small")
  `DTF_ASSERT(a_miss_zero, out_valid_r && !found_r, (offset_r | length_r) == '0, "miss not zeroed")

endmodule

@@ bench/tb_top.sv @@
// self-checking bench for the delimited token finder: strings go in one byte per
// transaction and each string's result is checked against a scan model kept here
// depends on dtf_pkg and delimited_token_finder_unit
`timescale 1ns / 1ps

module tb_top;

  typedef logic [dtf_pkg::BYTE_W-1:0] byte_t;
  typedef logic [dtf_pkg::POS_W-1:0]  pos_t;

  typedef struct packed {
    byte_t text;
    logic  last;
  } text_item_t;

  typedef struct packed {
    logic found;
    pos_t offset;
    pos_t length;
    logic too_long;
  } match_result_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  byte_t                         in_text_byte;
  logic                          in_last_byte;
  logic                          out_valid;
  logic                          out_stall;
  logic                          out_found;
  pos_t                          out_content_offset;
  pos_t                          out_content_length;
  logic                          out_too_long;
  logic                          cfg_wr_en;
  logic [dtf_pkg::CFG_IDX_W-1:0] cfg_index;
  byte_t                         cfg_wr_data;

  text_item_t    text_stream[$];
  match_result_t expected_matches[$];
  byte_t         text_buf[$];
  logic          in_taken;
  int            send_idle_pct;
  int            recv_stall_pct;
  int            mismatch_count;

  // scan model state
  byte_t open_ch;
  byte_t close_ch;
  pos_t  scan_pos;
  pos_t  cand_start;
  pos_t  hit_start;
  pos_t  hit_len;
  bit    dollar_seen;
  bit    cand_open;
  bit    cand_good;
  bit    cand_past_eq;
  bit    match_hit;
  bit    overflow_seen;

  delimited_token_finder_unit uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_text_byte       (in_text_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_found          (out_found),
    .out_content_offset (out_content_offset),
    .out_content_length (out_content_length),
    .out_too_long       (out_too_long),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wr_data        (cfg_wr_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // name characters allowed before the first equals sign
  function automatic bit is_name_char(input byte_t c);
    bit ok;
    ok = 1'b0;
    if (c >= 8'h61 && c <= 8'h7A) ok = 1'b1;         // a..z
    else if (c >= 8'h41 && c <= 8'h5A) ok = 1'b1;    // A..Z
    else if (c >= 8'h30 && c <= 8'h39) ok = 1'b1;    // 0..9
    else if (c >= 8'hC0) ok = (c != 8'hD7) && (c != 8'hF7);
    else ok = (c == dtf_pkg::CH_UNDER) || (c == dtf_pkg::CH_DASH) ||
              (c == dtf_pkg::CH_SLASH);
    return ok;
  endfunction

  function automatic void clear_scan_state();
    scan_pos      = '0;
    cand_start    = '0;
    hit_start     = '0;
    hit_len       = '0;
    dollar_seen   = 1'b0;
    cand_open     = 1'b0;
    cand_good     = 1'b1;
    cand_past_eq  = 1'b0;
    match_hit     = 1'b0;
    overflow_seen = 1'b0;
  endfunction

  // advance the scan by one byte; the last byte of a string yields one result
  function automatic void track_reference(input byte_t c, input logic last);
    match_result_t r;
    bit hit;
    if (scan_pos == dtf_pkg::MAX_LEN) begin
      overflow_seen = 1'b1;
    end else begin
      // pending candidate: close it or check its content
      if (!match_hit && cand_open) begin
        if (c == close_ch) begin
          if (cand_good) begin
            match_hit = 1'b1;
            hit_start = cand_start;
            hit_len   = scan_pos - cand_start;
          end
          cand_open = 1'b0;
        end else if (!cand_past_eq) begin
          if (c == dtf_pkg::CH_EQUALS) cand_past_eq = 1'b1;
          else if (!is_name_char(c)) cand_good = 1'b0;
        end
      end
      // a dollar-open pair replaces only a bad or absent candidate
      if (!match_hit && dollar_seen && c == open_ch && (!cand_open || !cand_good)) begin
        cand_open    = 1'b1;
        cand_good    = 1'b1;
        cand_past_eq = 1'b0;
        cand_start   = scan_pos + 16'd1;
      end
      dollar_seen = (c == dtf_pkg::CH_DOLLAR);
      scan_pos    = scan_pos + 16'd1;
    end
    if (last) begin
      hit        = match_hit && (overflow_seen || scan_pos >= dtf_pkg::MIN_MATCH_LEN);
      r.found    = hit;
      r.offset   = hit ? hit_start : '0;
      r.length   = hit ? hit_len : '0;
      r.too_long = overflow_seen;
      expected_matches.push_back(r);
      clear_scan_state();
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // input driver: a new transaction only once the previous one is taken
  always @(negedge clk) begin
    text_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (text_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        it = text_stream.pop_front();
        in_valid     <= 1'b1;
        in_text_byte <= it.text;
        in_last_byte <= it.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // monitor: feed accepted bytes to the scan model and check results
  always @(posedge clk) begin
    match_result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) track_reference(in_text_byte, in_last_byte);
      if (out_valid && !out_stall) begin
        if (expected_matches.size() == 0) begin
          report_mismatch("result with no string pending");
        end else begin
          want = expected_matches.pop_front();
          if (out_found !== want.found)
            report_mismatch($sformatf("found got %0d want %0d", out_found, want.found));
          if (out_content_offset !== want.offset)
            report_mismatch($sformatf("content_offset got %0d want %0d",
                                      out_content_offset, want.offset));
          if (out_content_length !== want.length)
            report_mismatch($sformatf("content_length got %0d want %0d",
                                      out_content_length, want.length));
          if (out_too_long !== want.too_long)
            report_mismatch($sformatf("too_long got %0d want %0d",
                                      out_too_long, want.too_long));
        end
      end
    end
    in_taken <= rst_n && in_valid && !in_stall;
  end

  // move the byte buffer into the stream as one string
  task automatic queue_text();
    text_item_t it;
    foreach (text_buf[i]) begin
      it.text = text_buf[i];
      it.last = (i == text_buf.size() - 1);
      text_stream.push_back(it);
    end
    text_buf.delete();
  endtask

  task automatic add_chars(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  function automatic byte_t name_char();
    byte_t c;
    case ($urandom_range(6))
      0: c = 8'h61 + byte_t'($urandom_range(25));
      1: c = 8'h41 + byte_t'($urandom_range(25));
      2: c = 8'h30 + byte_t'($urandom_range(9));
      3: begin
        c = 8'hC0 + byte_t'($urandom_range(63));
        if (c == 8'hD7 || c == 8'hF7) c = 8'hC0;
      end
      4: c = dtf_pkg::CH_UNDER;
      5: c = dtf_pkg::CH_DASH;
      default: c = dtf_pkg::CH_SLASH;
    endcase
    return c;
  endfunction

  // noise leaning on the bytes that steer the scan
  function automatic byte_t noise_char();
    int pick;
    pick = $urandom_range(99);
    if (pick < 20) return dtf_pkg::CH_DOLLAR;
    if (pick < 32) return open_ch;
    if (pick < 44) return close_ch;
    if (pick < 52) return dtf_pkg::CH_EQUALS;
    return byte_t'($urandom_range(255));
  endfunction

  // mostly well-formed references with random content, some broken, some noise
  task automatic build_random_string();
    int kind;
    int n;
    kind = $urandom_range(99);
    repeat ($urandom_range(4)) text_buf.push_back(noise_char());
    if (kind < 75) begin
      text_buf.push_back(dtf_pkg::CH_DOLLAR);
      text_buf.push_back(open_ch);
      n = $urandom_range(8);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(9) == 0) text_buf.push_back(dtf_pkg::CH_EQUALS);
        else if ($urandom_range(9) == 0) text_buf.push_back(byte_t'($urandom_range(255)));
        else text_buf.push_back(name_char());
      end
      if (kind < 12) text_buf.push_back(noise_char());
      if (kind >= 6) text_buf.push_back(close_ch);
      repeat ($urandom_range(3)) text_buf.push_back(noise_char());
    end else begin
      repeat ($urandom_range(1, 12)) text_buf.push_back(noise_char());
    end
  endtask

  // wait until every string is taken and its result checked
  task automatic wait_drained();
    do @(posedge clk);
    while (text_stream.size() != 0 || in_valid || expected_matches.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // both delimiter registers, written while the block is idle
  task automatic set_delimiters(input byte_t op, input byte_t cl);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= dtf_pkg::REG_OPEN_CHAR;
    cfg_wr_data <= op;
    @(negedge clk);
    cfg_index   <= dtf_pkg::REG_CLOSE_CHAR;
    cfg_wr_data <= cl;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    open_ch  = op;
    close_ch = cl;
  endtask

  task automatic run_random_phase(input byte_t op, input byte_t cl,
                                  input int send_pct, input int recv_pct, input int n_bytes);
    int added;
    wait_drained();
    set_delimiters(op, cl);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    added = 0;
    while (added < n_bytes) begin
      build_random_string();
      added += text_buf.size();
      queue_text();
    end
  endtask

  // stimulus
  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_text_byte   = '0;
    in_last_byte   = 1'b0;
    out_stall      = 1'b0;
    in_taken       = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = dtf_pkg::REG_OPEN_CHAR;
    cfg_wr_data    = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
    open_ch        = dtf_pkg::OPEN_CHAR_RST;
    close_ch       = dtf_pkg::CLOSE_CHAR_RST;
    clear_scan_state();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed strings under the reset delimiters
    add_chars("$()");                    // valid but under the minimum length
    queue_text();
    add_chars("$(a)");
    queue_text();
    add_chars("$(!)$(=");                // bad candidate, then one past its equals
    text_buf.push_back(8'hFF);
    add_chars(")");
    queue_text();
    text_buf.push_back(8'h00);           // older candidate past equals wins the overlap
    add_chars("$(a=$(b))");
    queue_text();
    text_buf.push_back(8'hFF);           // single byte string
    queue_text();

    // random strings over several delimiter settings and idle patterns
    run_random_phase(8'h7B, 8'h7D, 58, 0, 100);
    run_random_phase(8'h00, 8'hFF, 0, 58, 100);
    run_random_phase(8'hFF, 8'h00, 23, 23, 100);
    run_random_phase(8'h7C, 8'h7C, 0, 0, 100);            // close equal to open
    run_random_phase(dtf_pkg::CH_DOLLAR, byte_t'($urandom_range(255)), 23, 23, 100);
    run_random_phase(byte_t'($urandom_range(255)), byte_t'($urandom_range(255)),
                     58, 0, 100);

    wait_drained();
    if (mismatch_count == 0) begin
      $display("delimited_token_finder_unit verification clean");
    end else begin
      $display("delimited_token_finder_unit verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("delimited_token_finder_unit verification failed");
    $finish;
  end

endmodule
